### src/tsg_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Triangle span generator package
// Shared types for the front (setup) and back (span walk) parts.
// ----------------------------------------------------------------------------
package tsg_pkg;

	localparam int CoordW = 12;
	localparam int YW = 11;
	localparam int EdgeW = 28;
	localparam int ColorW = 32;

	// One classified job handed from the setup part to the span walker.
	typedef struct packed {
		logic               tall;   // single flagged result
		logic               point;  // all vertices on one row
		logic               do_bot; // bottom part present
		logic               do_top; // top part present
		logic [YW-1:0]      y1;
		logic [YW-1:0]      y2;
		logic [YW-1:0]      y3;
		logic [EdgeW-1:0]   x1f;    // x1 in fixed point
		logic [EdgeW-1:0]   x3f;    // x3 in fixed point
		logic [EdgeW-1:0]   sa_b;   // bottom slopes
		logic [EdgeW-1:0]   sb_b;
		logic [EdgeW-1:0]   sa_t;   // top slopes
		logic [EdgeW-1:0]   sb_t;
		logic [ColorW-1:0]  color;
	} job_t;

endpackage
`default_nettype wire

### src/tsg_div.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Signed restoring divider
// Truncating signed division, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module tsg_div #(
	parameter int NW = 48,
	parameter int DW = 12
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 start,
	input  wire logic signed [NW-1:0] num,
	input  wire logic        [DW-1:0] den,
	output logic                      busy,
	output logic signed [NW-1:0]      quo
);
	localparam int CW = $clog2(NW + 1);

	logic [NW-1:0] q_q;
	logic [NW:0]   rem_q;
	logic [DW-1:0] den_q;
	logic          neg_q;
	logic [CW-1:0] cnt_q;
	logic [NW:0]   trial;
	logic [NW:0]   shifted;

	assign shifted = {rem_q[NW-1:0], q_q[NW-1]};
	assign trial = shifted - {{(NW+1-DW){1'b0}}, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= CW'(NW);
		end else if (cnt_q != '0) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			q_q <= num[NW-1] ? -num : num;
			neg_q <= num[NW-1];
			den_q <= den;
			rem_q <= '0;
		end else if (cnt_q != '0) begin
			if (!trial[NW]) begin
				rem_q <= trial;
				q_q <= {q_q[NW-2:0], 1'b1};
			end else begin
				rem_q <= shifted;
				q_q <= {q_q[NW-2:0], 1'b0};
			end
		end
	end

	assign busy = (cnt_q != '0);
	assign quo = neg_q ? -$signed(q_q) : $signed(q_q);
endmodule
`default_nettype wire

### src/tsg_setup.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Triangle setup
// Sorts vertices, classifies the triangle and computes split and slopes.
// ----------------------------------------------------------------------------
module tsg_setup #(
	parameter int MAX_ROWS = 64,
	parameter int FRAC_BITS = 16
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  in_valid,
	output logic                       in_ready,
	input  wire logic [tsg_pkg::CoordW-1:0] ax,
	input  wire logic [tsg_pkg::YW-1:0]     ay,
	input  wire logic [tsg_pkg::CoordW-1:0] bx,
	input  wire logic [tsg_pkg::YW-1:0]     by,
	input  wire logic [tsg_pkg::CoordW-1:0] cx,
	input  wire logic [tsg_pkg::YW-1:0]     cy,
	input  wire logic [tsg_pkg::ColorW-1:0] fill_color,
	output logic                       job_valid,
	input  wire logic                  job_ready,
	output tsg_pkg::job_t              job
);
	import tsg_pkg::*;

	localparam int NW = 48;
	localparam logic [2:0] ST_IDLE = 3'd0, ST_X4 = 3'd1, ST_SA = 3'd2,
		ST_SB = 3'd3, ST_TA = 3'd4, ST_TB = 3'd5, ST_OUT = 3'd6, ST_XD = 3'd7;

	logic [2:0] st_q;
	logic signed [13:0] x1_q, x2_q, x3_q, x4_q;
	logic [YW-1:0] y1_q, y2_q, y3_q;
	logic [ColorW-1:0] col_q;
	logic flat_bot, flat_top;
	job_t job_q;

	// sorting network, stable
	logic signed [13:0] sx0, sx1, sx2, px;
	logic [YW-1:0] sy0, sy1, sy2, py;
	function automatic logic signed [13:0] sx(input logic [CoordW-1:0] v);
		return 14'(signed'(v));
	endfunction

	always_comb begin
		px = '0; py = '0;
		sx0 = sx(ax); sy0 = ay;
		sx1 = sx(bx); sy1 = by;
		sx2 = sx(cx); sy2 = cy;
		if (sy0 > sy1) begin
			px = sx0; py = sy0; sx0 = sx1; sy0 = sy1; sx1 = px; sy1 = py;
		end
		if (sy1 > sy2) begin
			px = sx1; py = sy1; sx1 = sx2; sy1 = sy2; sx2 = px; sy2 = py;
		end
		if (sy0 > sy1) begin
			px = sx0; py = sy0; sx0 = sx1; sy0 = sy1; sx1 = px; sy1 = py;
		end
	end

	assign flat_bot = (y2_q == y3_q);
	assign flat_top = !flat_bot && (y1_q == y2_q);

	// divider operands
	logic [YW-1:0] d31, d21, d32;
	logic signed [NW-1:0] mprod_q;
	logic signed [NW-1:0] num;
	logic [YW-1:0] den;
	logic dstart, dbusy;
	logic signed [NW-1:0] quo;
	logic signed [13:0] xb, xl, xr;
	logic signed [25:0] p1, p2;

	assign d31 = y3_q - y1_q;
	assign d21 = y2_q - y1_q;
	assign d32 = y3_q - y2_q;
	assign xb = flat_bot ? x3_q : x4_q;
	assign xl = flat_top ? x1_q : x2_q;
	assign xr = flat_top ? x2_q : x4_q;

	// Split point numerator x1*(y3-y1) + (y2-y1)*(x3-x1), two small products.
	assign p1 = x1_q * signed'({1'b0, d31});
	assign p2 = signed'({1'b0, d21}) * (x3_q - x1_q);

	always_comb begin
		num = mprod_q;
		den = d31;
		unique case (st_q)
			ST_SA: begin
				num = NW'(signed'(x2_q - x1_q)) <<< FRAC_BITS; den = d21;
			end
			ST_SB: begin
				num = NW'(signed'(xb - x1_q)) <<< FRAC_BITS; den = d21;
			end
			ST_TA: begin
				num = NW'(signed'(x3_q - xl)) <<< FRAC_BITS; den = d32;
			end
			ST_TB: begin
				num = NW'(signed'(x3_q - xr)) <<< FRAC_BITS; den = d32;
			end
			default: begin
				num = mprod_q; den = d31;
			end
		endcase
	end

	logic go_q;
	assign dstart = go_q;

	tsg_div #(.NW(NW), .DW(YW)) u_div (
		.clk(clk), .arst_n(arst_n), .start(dstart), .num(num), .den(den),
		.busy(dbusy), .quo(quo)
	);

	logic [YW:0] cnt;
	assign cnt = flat_top ? {1'b0, d31} : {1'b0, d31} + 1'b1;

	assign in_ready = (st_q == ST_IDLE);
	assign job_valid = (st_q == ST_OUT);
	assign job = job_q;

	logic div_done;
	assign div_done = !go_q && !dbusy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE;
			go_q <= 1'b0;
		end else begin
			go_q <= 1'b0;
			unique case (st_q)
				ST_IDLE: if (in_valid) begin
					st_q <= ST_X4;
				end
				ST_X4: begin
					// classification needs the registered sort
					if (y1_q == y3_q || cnt > (YW+1)'(MAX_ROWS)) begin
						st_q <= ST_OUT;
					end else if (flat_top) begin
						st_q <= ST_TA; go_q <= 1'b1;
					end else if (flat_bot) begin
						st_q <= ST_SA; go_q <= 1'b1;
					end else begin
						st_q <= ST_XD; go_q <= 1'b1;
					end
				end
				ST_XD: if (div_done) begin
					st_q <= ST_SA; go_q <= 1'b1;
				end
				ST_SA: if (div_done) begin
					st_q <= ST_SB; go_q <= 1'b1;
				end
				ST_SB: if (div_done) begin
					st_q <= flat_bot ? ST_OUT : ST_TA;
					go_q <= !flat_bot;
				end
				ST_TA: if (div_done) begin
					st_q <= ST_TB; go_q <= 1'b1;
				end
				ST_TB: if (div_done) begin
					st_q <= ST_OUT;
				end
				ST_OUT: if (job_ready) begin
					st_q <= ST_IDLE;
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (st_q == ST_IDLE && in_valid) begin
			x1_q <= sx0; y1_q <= sy0;
			x2_q <= sx1; y2_q <= sy1;
			x3_q <= sx2; y3_q <= sy2;
			col_q <= fill_color;
		end
		if (st_q == ST_XD && div_done) begin
			x4_q <= 14'(quo);
		end
		if (st_q == ST_SB && div_done) job_q.sb_b <= EdgeW'(quo);
		if (st_q == ST_SA && div_done) job_q.sa_b <= EdgeW'(quo);
		if (st_q == ST_TA && div_done) job_q.sa_t <= EdgeW'(quo);
		if (st_q == ST_TB && div_done) job_q.sb_t <= EdgeW'(quo);
		if (st_q == ST_X4) begin
			mprod_q <= NW'(p1) + NW'(p2);
			job_q.point <= (y1_q == y3_q);
			job_q.tall <= (y1_q != y3_q) && (cnt > (YW+1)'(MAX_ROWS));
			job_q.do_bot <= !flat_top;
			job_q.do_top <= !flat_bot;
			job_q.y1 <= y1_q; job_q.y2 <= y2_q; job_q.y3 <= y3_q;
			job_q.x1f <= EdgeW'(x1_q) << FRAC_BITS;
			job_q.x3f <= EdgeW'(x3_q) << FRAC_BITS;
			job_q.color <= col_q;
		end
	end
endmodule
`default_nettype wire

### src/tsg_fifo.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Job queue
// Two-entry queue between setup and span walker.
// ----------------------------------------------------------------------------
module tsg_fifo (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          wr_valid,
	output logic               wr_ready,
	input  wire tsg_pkg::job_t wr_data,
	output logic               rd_valid,
	input  wire logic          rd_ready,
	output tsg_pkg::job_t      rd_data
);
	import tsg_pkg::*;

	job_t mem_q [2];
	logic wp_q, rp_q;
	logic [1:0] cnt_q;
	logic wr, rd;

	assign wr_ready = (cnt_q != 2'd2);
	assign rd_valid = (cnt_q != 2'd0);
	assign wr = wr_valid && wr_ready;
	assign rd = rd_valid && rd_ready;
	assign rd_data = mem_q[rp_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0; rp_q <= 1'b0; cnt_q <= '0;
		end else begin
			if (wr) wp_q <= !wp_q;
			if (rd) rp_q <= !rp_q;
			cnt_q <= cnt_q + {1'b0, wr} - {1'b0, rd};
		end
	end

	always_ff @(posedge clk) begin
		if (wr) mem_q[wp_q] <= wr_data;
	end
endmodule
`default_nettype wire

### src/tsg_walk.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Span walker
// Steps both edges row by row and emits one span a cycle unless the output is stalled.
// ----------------------------------------------------------------------------
module tsg_walk (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  job_valid,
	output logic                       job_ready,
	input  wire tsg_pkg::job_t         job,
	output logic                       out_valid,
	input  wire logic                  out_ready,
	output logic [tsg_pkg::YW-1:0]     row,
	output logic [tsg_pkg::EdgeW-1:0]  edge_a,
	output logic [tsg_pkg::EdgeW-1:0]  edge_b,
	output logic [tsg_pkg::ColorW-1:0] span_color,
	output logic                       last_span,
	output logic                       too_tall
);
	import tsg_pkg::*;

	localparam logic [1:0] W_IDLE = 2'd0, W_BOT = 2'd1, W_TOP = 2'd2;

	logic [1:0] st_q;
	job_t j_q;
	logic [YW-1:0] r_q;
	logic [EdgeW-1:0] ea_q, eb_q;
	logic ov_q;
	logic take, emit, last;

	assign job_ready = (st_q == W_IDLE);
	assign take = job_valid && job_ready;
	assign emit = (st_q != W_IDLE) && (!ov_q || out_ready);
	assign last = (st_q == W_BOT) ? (r_q == j_q.y2 && !j_q.do_top)
		: (r_q == j_q.y2 + 1'b1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= W_IDLE; ov_q <= 1'b0;
		end else begin
			if (out_ready) ov_q <= 1'b0;
			if (take) begin
				st_q <= (job.point || job.tall) ? W_BOT : job.do_bot ? W_BOT : W_TOP;
			end else if (emit) begin
				ov_q <= 1'b1;
				if (j_q.point || j_q.tall || last) st_q <= W_IDLE;
				else if (st_q == W_BOT && r_q == j_q.y2) st_q <= W_TOP;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			j_q <= job;
			if (job.point || job.tall || job.do_bot) begin
				r_q <= job.y1; ea_q <= job.x1f; eb_q <= job.x1f;
			end else begin
				r_q <= job.y3; ea_q <= job.x3f; eb_q <= job.x3f;
			end
		end else if (emit) begin
			row <= r_q;
			edge_a <= j_q.tall ? '0 : ea_q;
			edge_b <= j_q.tall ? '0 : eb_q;
			span_color <= j_q.color;
			too_tall <= j_q.tall;
			last_span <= j_q.point || j_q.tall || last;
			if (st_q == W_BOT && r_q == j_q.y2) begin
				r_q <= j_q.y3; ea_q <= j_q.x3f; eb_q <= j_q.x3f;
			end else if (st_q == W_BOT) begin
				r_q <= r_q + 1'b1;
				ea_q <= ea_q + j_q.sa_b; eb_q <= eb_q + j_q.sb_b;
			end else begin
				r_q <= r_q - 1'b1;
				ea_q <= ea_q - j_q.sa_t; eb_q <= eb_q - j_q.sb_t;
			end
		end
	end

	assign out_valid = ov_q;

	a_valid_held: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> out_valid)
		else $error("result dropped while stalled");
	a_tall_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && too_tall) |-> last_span)
		else $error("flagged result not last");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> $stable(row) && $stable(edge_a))
		else $error("result changed while stalled");
endmodule
`default_nettype wire

### src/triangle_span_generator_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Triangle span generator
// Scanline fill of a triangle split into flat-bottom and flat-top parts.
// ----------------------------------------------------------------------------
// A request carries three vertices and a color. The setup part sorts the
// vertices by y, classifies the triangle and works out the split point and
// the inverse slopes on a shared bit-serial divider, one quotient bit per
// cycle. A general triangle needs five divides; a flat-top or flat-bottom
// triangle needs two; a single-row or too-tall triangle needs none. The span
// walker then emits one span per cycle while the output is not stalled, up to
// MAX_ROWS spans, so the setup sets the rate for general triangles. A
// two-entry job queue lets setup of the next triangle overlap the walk of the
// current one.
module triangle_span_generator_unit #(
	parameter int MAX_ROWS = 64,
	parameter int FRAC_BITS = 16
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       in_valid,
	output logic                            in_ready,
	input  wire logic [tsg_pkg::CoordW-1:0] ax,
	input  wire logic [tsg_pkg::YW-1:0]     ay,
	input  wire logic [tsg_pkg::CoordW-1:0] bx,
	input  wire logic [tsg_pkg::YW-1:0]     by,
	input  wire logic [tsg_pkg::CoordW-1:0] cx,
	input  wire logic [tsg_pkg::YW-1:0]     cy,
	input  wire logic [tsg_pkg::ColorW-1:0] fill_color,
	output logic                            out_valid,
	input  wire logic                       out_ready,
	output logic [tsg_pkg::YW-1:0]          row,
	output logic [tsg_pkg::EdgeW-1:0]       edge_a,
	output logic [tsg_pkg::EdgeW-1:0]       edge_b,
	output logic [tsg_pkg::ColorW-1:0]      span_color,
	output logic                            last_span,
	output logic                            too_tall
);
	import tsg_pkg::*;

	job_t s_job, q_job;
	logic s_v, s_r, q_v, q_r;

	// Triangle classification and slope setup.
	tsg_setup #(.MAX_ROWS(MAX_ROWS), .FRAC_BITS(FRAC_BITS))
	u_setup (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
		.ax(ax), .ay(ay), .bx(bx), .by(by), .cx(cx), .cy(cy),
		.fill_color(fill_color), .job_valid(s_v), .job_ready(s_r), .job(s_job)
	);

	// Decoupling queue.
	tsg_fifo u_fifo (
		.clk(clk), .arst_n(arst_n), .wr_valid(s_v), .wr_ready(s_r),
		.wr_data(s_job), .rd_valid(q_v), .rd_ready(q_r), .rd_data(q_job)
	);

	// Row walker and result register.
	tsg_walk u_walk (
		.clk(clk), .arst_n(arst_n), .job_valid(q_v), .job_ready(q_r), .job(q_job),
		.out_valid(out_valid), .out_ready(out_ready), .row(row),
		.edge_a(edge_a), .edge_b(edge_b), .span_color(span_color),
		.last_span(last_span), .too_tall(too_tall)
	);
endmodule
`default_nettype wire
